// File: rtl/chb_pkg.sv
// Shared types and constants for the cumulative bucket histogram.
// No dependencies; imported by every module of the block.
package chb_pkg;

	localparam int NUM_BUCKETS_DEF = 8;
	localparam int MAX_FINITE      = 7;
	localparam int CFG_ADDR_W      = 5;
	localparam int REG_IDX_W       = 3;
	localparam int USED_W          = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [USED_W-1:0]    used_t;
	typedef logic signed [31:0]   q16_t;
	typedef logic [63:0]          count_t;
	typedef logic signed [63:0]   sum_t;

	localparam reg_idx_t REG_BOUNDS_IN_USE = 3'd0;

	localparam logic KIND_OBSERVE = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	typedef struct packed {
		logic kind;
		q16_t sample;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] bucket_index;
		logic       bound_is_infinite;
		q16_t       bucket_bound;
		count_t     cumulative_count;
		count_t     total_count;
		sum_t       total_sum;
		logic       last;
	} out_beat_t;

	typedef struct packed {
		logic observe;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/chb_regs.sv
// APB register file: bounds_in_use and the seven finite bounds.
// Depends on chb_pkg.
module chb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output chb_pkg::used_t                 bounds_in_use,
	output chb_pkg::q16_t                  bounds [chb_pkg::MAX_FINITE]
);
	import chb_pkg::*;

	reg_idx_t idx;
	reg_idx_t bidx;
	logic     wr_en;
	used_t    biu_q;
	q16_t     bound_q [MAX_FINITE];

	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign bidx   = idx - 3'd1;
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= '0;
			for (int i = 0; i < MAX_FINITE; i++) bound_q[i] <= '0;
		end else if (wr_en) begin
			if (idx == REG_BOUNDS_IN_USE) begin
				biu_q <= pwdata[USED_W-1:0];
			end else begin
				bound_q[bidx] <= pwdata;
			end
		end
	end

	always_comb begin
		if (idx == REG_BOUNDS_IN_USE) begin
			prdata = {{(32-USED_W){1'b0}}, biu_q};
		end else begin
			prdata = bound_q[bidx];
		end
	end

	assign bounds_in_use = biu_q;
	assign bounds        = bound_q;

endmodule

// File: rtl/chb_cell.sv
// One bucket cell: bound compare, priority hand-off and 64-bit counter.
// Counters rotate toward cell 0 during read-out. Depends on chb_pkg.
module chb_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  chb_pkg::cell_ctrl_t ctrl,
	input  chb_pkg::q16_t       sample,
	input  chb_pkg::q16_t       bound,
	input  logic                is_inf,
	input  logic                in_range,
	input  logic                taken_in,
	input  chb_pkg::count_t     shift_in,
	output logic                taken_out,
	output chb_pkg::count_t     count
);
	import chb_pkg::*;

	logic   match;
	logic   hit;
	count_t count_q;

	assign match     = is_inf | (in_range & (bound >= sample));
	assign hit       = ctrl.observe & match & ~taken_in;
	assign taken_out = taken_in | match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.shift) begin
			count_q <= shift_in;
		end else if (hit) begin
			count_q <= count_q + 64'd1;
		end
	end

	assign count = count_q;

endmodule

// File: rtl/cumulative_bucket_histogram.sv
// Top level of the cumulative bucket histogram: FSM, sum, read-out.
// Depends on chb_pkg, chb_regs and chb_cell.
//
// Usage:
//  Commands enter on cmd when start is high and busy is low. An observe
//  command updates the saturating sum and the matching bucket counter at
//  the accepting edge; observes are taken every idle cycle and never raise
//  busy. A read command raises busy for a total phase and an emit phase.
//  The counters rotate once around the cell chain to form the total count,
//  then once more to emit one result per bucket up to the +Inf bucket,
//  lowest bound first. Results leave on result, marked by result_valid for
//  one cycle each; the first follows the total phase, then one per cycle,
//  with last set on the +Inf bucket. The receiver cannot stall; results are
//  simply presented. The user must write bounds and bounds_in_use over
//  the APB port only while idle; the block itself does not enforce this.
//  Reset clears counters, sum and registers; the block is ready at once.
module cumulative_bucket_histogram #(
	parameter int NUM_BUCKETS = chb_pkg::NUM_BUCKETS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  chb_pkg::in_beat_t              cmd,
	output logic                           result_valid,
	output chb_pkg::out_beat_t             result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import chb_pkg::*;

	localparam int STEP_W = $clog2(NUM_BUCKETS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_BUCKETS - 1);
	localparam used_t MAX_USED = USED_W'(NUM_BUCKETS - 1);

	used_t      bounds_in_use;
	q16_t       bounds [MAX_FINITE];
	q16_t       bound_view [NUM_BUCKETS];
	used_t      used;
	state_t     state_q;
	state_t     state_d;
	logic [STEP_W-1:0] step_q;
	logic       step_end;
	logic       step_in;
	logic       accept;
	logic       obs_go;
	logic       read_go;
	cell_ctrl_t ctrl;
	logic       taken [NUM_BUCKETS+1];
	count_t     counts [NUM_BUCKETS];
	count_t     head;
	count_t     total_q;
	count_t     running_q;
	count_t     running_nx;
	sum_t       sum_q;
	sum_t       sample_ext;
	sum_t       sum_raw;
	logic       sum_ovf;
	logic       head_inf;
	logic       valid_q;
	out_beat_t  out_q;

	chb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.bounds_in_use(bounds_in_use),
		.bounds       (bounds)
	);

	assign used = (bounds_in_use > MAX_USED) ? MAX_USED : bounds_in_use;

	always_comb begin
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			bound_view[i] = (i < MAX_FINITE) ? bounds[i] : '0;
		end
	end

	assign accept   = start & ~busy;
	assign obs_go   = accept & (cmd.kind == KIND_OBSERVE);
	assign read_go  = accept & (cmd.kind == KIND_READ);
	assign step_end = (step_q == LAST_STEP);
	assign step_in  = ({1'b0, 3'(step_q)} <= {1'b0, used});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (read_go) state_d = ST_TOTAL;
			ST_TOTAL: if (step_end) state_d = ST_EMIT;
			ST_EMIT:  if (step_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = 1'b1;
		ctrl.observe = 1'b0;
		ctrl.shift   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy         = 1'b0;
				ctrl.observe = obs_go;
			end
			ST_TOTAL, ST_EMIT: ctrl.shift = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	assign taken[0] = 1'b0;

	for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
		chb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sample   (cmd.sample),
			.bound    (bound_view[i]),
			.is_inf   (USED_W'(i) == used),
			.in_range (USED_W'(i) < used),
			.taken_in (taken[i]),
			.shift_in (counts[(i + 1) % NUM_BUCKETS]),
			.taken_out(taken[i+1]),
			.count    (counts[i])
		);
	end

	assign head = counts[0];

	assign sample_ext = 64'(cmd.sample);
	assign sum_raw    = sum_q + sample_ext;
	assign sum_ovf    = (sum_q[63] == sample_ext[63]) && (sum_raw[63] != sum_q[63]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == ST_EMIT) & step_in;
			if (state_q == ST_IDLE) begin
				step_q <= '0;
			end else begin
				step_q <= step_end ? '0 : step_q + 1'b1;
			end
			if (obs_go) begin
				if (sum_ovf) begin
					sum_q <= sample_ext[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				end else begin
					sum_q <= sum_raw;
				end
			end
		end
	end

	assign running_nx = running_q + head;
	assign head_inf   = (3'(step_q) == used);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				total_q   <= '0;
				running_q <= '0;
			end
			ST_TOTAL: begin
				if (step_in) total_q <= total_q + head;
			end
			ST_EMIT: begin
				running_q <= running_nx;
			end
			default: running_q <= running_q;
		endcase
		out_q.bucket_index      <= 3'(step_q);
		out_q.bound_is_infinite <= head_inf;
		out_q.bucket_bound      <= head_inf ? '0 : bound_view[step_q];
		out_q.cumulative_count  <= running_nx;
		out_q.total_count       <= total_q;
		out_q.total_sum         <= sum_q;
		out_q.last              <= head_inf;
	end

	assign result_valid = valid_q;
	assign result       = out_q;

endmodule
